[rtl/core/msc_pkg.sv]
// Shared types and constants for the marquee scroll and crop controller.
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

   localparam int PIX_W      = 16;
   localparam int HOLD_W     = 15;
   localparam int DIVIDEND_W = 32;
   localparam int DIVISOR_W  = 16;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
   localparam int SPAN10_W   = 20;
   localparam int TOTAL_W    = SPAN10_W + 1;

   localparam logic [DIVISOR_W-1:0] SPEED_DIV = DIVISOR_W'(10);

   // floor(x / 10) for any 32-bit x is (x * DIV10_RECIP) >> DIV10_SHIFT
   localparam int                    RECIP_W     = 2 * DIVIDEND_W;
   localparam logic [DIVIDEND_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int                    DIV10_SHIFT = 35;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_WINDOW_WIDTH = 2'd0,
      REG_SCROLL_SPEED = 2'd1,
      REG_HOLD_LENGTH  = 2'd2,
      REG_FADE_LIMIT   = 2'd3
   } reg_index_type;

   typedef enum logic [0:0] {
      REQ_SET_WIDTH = 1'b0,
      REQ_TICK      = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_TOTAL,
      ST_STEP,
      ST_MULT,
      ST_START_OFS,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic [PIX_W-1:0]  window_width;
      logic [PIX_W-1:0]  scroll_speed;
      logic [HOLD_W-1:0] hold_length;
      logic [PIX_W-1:0]  fade_limit;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic start_total;
      logic frame_step;
      logic mult;
      logic start_offset;
      logic deliver;
   } cmd_type;

   typedef struct packed {
      logic scroll_tick;
      logic div_busy;
   } status_type;

endpackage

`default_nettype wire

[rtl/core/msc_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module msc_divider (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [msc_pkg::DIVIDEND_W-1:0]   dividend,
   input  wire logic [msc_pkg::DIVISOR_W-1:0]    divisor,
   output logic                                  busy,
   output logic [msc_pkg::DIVIDEND_W-1:0]        quotient
);
   import msc_pkg::*;

   logic                    busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]    count_ff, count_in;
   logic [DIVIDEND_W-1:0]   quo_ff, quo_in;
   logic [DIVISOR_W:0]      rem_ff, rem_in;
   logic [DIVISOR_W-1:0]    dsr_ff, dsr_in;
   logic [DIVISOR_W:0]      rem_shift;

   always_comb begin
      busy_in   = busy_ff;
      count_in  = count_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      rem_shift = {rem_ff[DIVISOR_W-1:0], quo_ff[DIVIDEND_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = DIV_CNT_W'(DIVIDEND_W - 1);
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (rem_shift >= {1'b0, dsr_ff}) begin
            rem_in = rem_shift - {1'b0, dsr_ff};
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/core/msc_datapath.sv]
// Text width and frame state, cycle length and offset arithmetic, result registers.
`timescale 1ns / 1ps
`default_nettype none

module msc_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire msc_pkg::cfg_type              cfg,
   input  wire msc_pkg::cmd_type              cmd,
   output msc_pkg::status_type                status,
   input  wire logic                          req_type,
   input  wire logic [msc_pkg::PIX_W-1:0]     req_new_text_width,
   output logic [msc_pkg::PIX_W-1:0]          rsp_draw_width,
   output logic [msc_pkg::PIX_W-1:0]          rsp_pixel_offset,
   output logic [msc_pkg::PIX_W-1:0]          rsp_fade_left,
   output logic [msc_pkg::PIX_W-1:0]          rsp_fade_right,
   output logic [msc_pkg::PIX_W-1:0]          rsp_frame_index
);
   import msc_pkg::*;

   logic [PIX_W-1:0]      stored_ff, stored_in;
   logic [PIX_W-1:0]      frame_ff, frame_in;
   logic                  tick_ff, tick_in;
   logic [DIVIDEND_W-1:0] product_ff, product_in;
   logic [DIVIDEND_W-1:0] ofs_q_ff, ofs_q_in;
   logic [PIX_W-1:0]      draw_ff, offset_ff, fade_l_ff, fade_r_ff, index_ff;
   logic [PIX_W-1:0]      draw_in, offset_in, fade_l_in, fade_r_in;

   logic [PIX_W-1:0]      eff_speed, span_tick, span, frame_next, ofs_frames, rest;
   logic [SPAN10_W-1:0]   span10;
   logic [TOTAL_W-1:0]    total;
   logic [RECIP_W-1:0]    recip_prod;
   logic                  narrow;
   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend, quotient;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic                  div_busy;

   msc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      eff_speed  = (cfg.scroll_speed == '0) ? PIX_W'(1) : cfg.scroll_speed;
      narrow     = stored_ff < cfg.window_width;
      span_tick  = stored_ff - cfg.window_width;
      span10     = ({4'b0, span_tick} << 3) + ({4'b0, span_tick} << 1);
      total      = {1'b0, quotient[SPAN10_W-1:0]}
                 + {5'b0, cfg.hold_length, 1'b0};
      frame_next = frame_ff + 1'b1;
      ofs_frames = frame_ff - {1'b0, cfg.hold_length};
      // divide the scaled frame count by ten with a reciprocal multiply
      recip_prod = RECIP_W'(product_ff) * RECIP_W'(DIV10_RECIP);
      draw_in    = narrow ? stored_ff : cfg.window_width;
      span       = stored_ff - draw_in;
      offset_in  = (ofs_q_ff > {16'b0, span}) ? span : ofs_q_ff[PIX_W-1:0];
      rest       = span - offset_in;
      fade_l_in  = (offset_in < cfg.fade_limit) ? offset_in : cfg.fade_limit;
      fade_r_in  = (rest < cfg.fade_limit) ? rest : cfg.fade_limit;

      div_start    = cmd.start_total;
      div_dividend = {12'b0, span10};
      div_divisor  = eff_speed;

      stored_in  = stored_ff;
      frame_in   = frame_ff;
      tick_in    = tick_ff;
      product_in = product_ff;
      ofs_q_in   = ofs_q_ff;
      if (cmd.accept) begin
         tick_in = (req_type == REQ_TICK);
         if (req_type == REQ_SET_WIDTH) begin
            if (stored_ff != req_new_text_width) begin
               stored_in = req_new_text_width;
               frame_in  = '0;
            end
         end else if (narrow) begin
            frame_in = '0;
         end
      end
      if (cmd.frame_step) begin
         frame_in = ({5'b0, frame_next} >= total) ? '0 : frame_next;
      end
      if (cmd.mult) begin
         product_in = (frame_ff < {1'b0, cfg.hold_length}) ? '0
                    : {16'b0, ofs_frames} * {16'b0, eff_speed};
      end
      if (cmd.start_offset) begin
         ofs_q_in = DIVIDEND_W'(recip_prod[RECIP_W-1:DIV10_SHIFT]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= '0;
         frame_ff  <= '0;
      end else begin
         stored_ff <= stored_in;
         frame_ff  <= frame_in;
      end
      tick_ff    <= tick_in;
      product_ff <= product_in;
      ofs_q_ff   <= ofs_q_in;
      if (cmd.deliver) begin
         draw_ff   <= draw_in;
         offset_ff <= offset_in;
         fade_l_ff <= fade_l_in;
         fade_r_ff <= fade_r_in;
         index_ff  <= frame_ff;
      end
   end

   assign status.scroll_tick = tick_ff && !narrow;
   assign status.div_busy    = div_busy;

   assign rsp_draw_width   = draw_ff;
   assign rsp_pixel_offset = offset_ff;
   assign rsp_fade_left    = fade_l_ff;
   assign rsp_fade_right   = fade_r_ff;
   assign rsp_frame_index  = index_ff;

endmodule

`default_nettype wire

[rtl/core/msc_ctrl.sv]
// Sequencing state machine and channel handshake.
`timescale 1ns / 1ps
`default_nettype none

module msc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire msc_pkg::status_type status,
   output msc_pkg::cmd_type         cmd
);
   import msc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.scroll_tick) begin
               cmd.start_total = 1'b1;
               state_in        = ST_DIV_TOTAL;
            end else begin
               state_in = ST_MULT;
            end
         end
         ST_DIV_TOTAL: begin
            if (!status.div_busy) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.frame_step = 1'b1;
            state_in       = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_START_OFS;
         end
         ST_START_OFS: begin
            cmd.start_offset = 1'b1;
            state_in         = ST_DELIVER;
         end
         ST_DELIVER: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.deliver  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[rtl/core/marquee_scroll_crop_controller.sv]
// Top level of the marquee scroll and crop controller: register port, control and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Marquee scroll sequencer. Each request transaction either sets the text
// width (req_type 0; the frame counter clears only when the width changes)
// or advances one frame tick (req_type 1), and each one yields exactly one
// response transaction with the crop: draw width, pixel offset, left and
// right fade widths and the frame index after the update. Timing: a request
// is taken only while the block is idle. A tick on text at least as wide as
// the window runs a serial divide for the cycle length, then the frame step,
// the offset multiply and the divide by ten before the response is offered;
// a set-width request or a tick on narrow text skips the divide and the frame
// step. A stalled earlier response holds the delivery back. The next request
// is accepted at the edge after the one that loads a response, even while
// that response is still stalled.
// Registers (APB-style, always ready, 4-byte stride): 0 window_width,
// 1 scroll_speed (0 acts as 1, reset 10), 2 hold_length (15 bits),
// 3 fade_limit. Write them only while idle.

module marquee_scroll_crop_controller (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [msc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [msc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [msc_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_type,
   input  wire logic [msc_pkg::PIX_W-1:0]        req_new_text_width,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [msc_pkg::PIX_W-1:0]             rsp_draw_width,
   output logic [msc_pkg::PIX_W-1:0]             rsp_pixel_offset,
   output logic [msc_pkg::PIX_W-1:0]             rsp_fade_left,
   output logic [msc_pkg::PIX_W-1:0]             rsp_fade_right,
   output logic [msc_pkg::PIX_W-1:0]             rsp_frame_index
);
   import msc_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_sel;
   logic          csr_write;
   cmd_type       cmd;
   status_type    status;

   // Register port: word address selects the register, data masked to width.
   assign pready    = 1'b1;
   assign reg_sel   = reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_WINDOW_WIDTH: cfg_in.window_width = pwdata[PIX_W-1:0];
            REG_SCROLL_SPEED: cfg_in.scroll_speed = pwdata[PIX_W-1:0];
            REG_HOLD_LENGTH:  cfg_in.hold_length  = pwdata[HOLD_W-1:0];
            REG_FADE_LIMIT:   cfg_in.fade_limit   = pwdata[PIX_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_WINDOW_WIDTH: prdata = {16'b0, cfg_ff.window_width};
         REG_SCROLL_SPEED: prdata = {16'b0, cfg_ff.scroll_speed};
         REG_HOLD_LENGTH:  prdata = {17'b0, cfg_ff.hold_length};
         REG_FADE_LIMIT:   prdata = {16'b0, cfg_ff.fade_limit};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_width <= '0;
         cfg_ff.scroll_speed <= PIX_W'(10);
         cfg_ff.hold_length  <= '0;
         cfg_ff.fade_limit   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Sequencer: accepts one request, steps the datapath, offers the response.
   msc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: text width and frame state, serial divider, result registers.
   msc_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .cmd                (cmd),
      .status             (status),
      .req_type           (req_type),
      .req_new_text_width (req_new_text_width),
      .rsp_draw_width     (rsp_draw_width),
      .rsp_pixel_offset   (rsp_pixel_offset),
      .rsp_fade_left      (rsp_fade_left),
      .rsp_fade_right     (rsp_fade_right),
      .rsp_frame_index    (rsp_frame_index)
   );

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the marquee scroll and crop controller.
`timescale 1ns / 1ps

module tb_top;
   import msc_pkg::*;

   // One crop transaction as the block reports it.
   typedef struct packed {
      logic [PIX_W-1:0] draw;
      logic [PIX_W-1:0] offset;
      logic [PIX_W-1:0] fade_l;
      logic [PIX_W-1:0] fade_r;
      logic [PIX_W-1:0] frame;
   } crop_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   // One row of the directed table: either a request or a register write.
   typedef struct {
      row_kind_type     row;
      req_kind_type     kind;
      logic [PIX_W-1:0] width;
      reg_index_type    csr_index;
      logic [31:0]      value;
      bit               typed;
      crop_type         want;
   } stim_row_type;

   localparam int RANDOM_ITEMS   = 900;
   localparam int HOLD_OFF_LEN   = 400;   // several item latencies, enough to back up the input
   localparam int SETTLE_CYCLES  = 100;   // longer than the latency of a tick

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_type;
   logic [PIX_W-1:0]      req_new_text_width;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [PIX_W-1:0]      rsp_draw_width;
   logic [PIX_W-1:0]      rsp_pixel_offset;
   logic [PIX_W-1:0]      rsp_fade_left;
   logic [PIX_W-1:0]      rsp_fade_right;
   logic [PIX_W-1:0]      rsp_frame_index;

   // Shadow copy of the registers and of the marquee state.
   logic [PIX_W-1:0]  cfg_window;
   logic [PIX_W-1:0]  cfg_speed;
   logic [HOLD_W-1:0] cfg_hold;
   logic [PIX_W-1:0]  cfg_fade;
   logic [PIX_W-1:0]  model_text;
   logic [PIX_W-1:0]  model_frame;

   crop_type     pending_crops[$];
   stim_row_type dir_rows[$];
   int           error_count = 0;
   int           hold_offs_pending = 0;
   bit           idle_on = 1'b1;

   marquee_scroll_crop_controller uut (
      .clock              (clock),
      .reset              (reset),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_new_text_width (req_new_text_width),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_draw_width     (rsp_draw_width),
      .rsp_pixel_offset   (rsp_pixel_offset),
      .rsp_fade_left      (rsp_fade_left),
      .rsp_fade_right     (rsp_fade_right),
      .rsp_frame_index    (rsp_frame_index)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // Apply one request to the shadow state and return the crop it yields.
   function automatic crop_type advance_marquee(input req_kind_type kind,
                                                input logic [PIX_W-1:0] width);
      logic [16:0]      spd;
      logic [31:0]      total;
      logic [63:0]      pix;
      logic [PIX_W-1:0] draw;
      logic [PIX_W-1:0] span;
      logic [PIX_W-1:0] cur;
      logic [PIX_W-1:0] rest;
      crop_type         res;
      // a speed of zero scrolls like a speed of one
      spd = (cfg_speed == '0) ? 17'd1 : {1'b0, cfg_speed};
      if (kind == REQ_SET_WIDTH) begin
         if (model_text != width) begin
            model_text  = width;
            model_frame = '0;
         end
      end else if (model_text < cfg_window) begin
         model_frame = '0;   // text fits: frame pinned at zero
      end else begin
         model_frame = model_frame + 16'd1;
         // full cycle: hold, scroll, hold; no truncation to 16 bits
         total = ((32'(model_text) - 32'(cfg_window)) * 32'(SPEED_DIV)) / 32'(spd)
                 + 32'(cfg_hold) * 32'd2;
         if (32'(model_frame) >= total)
            model_frame = '0;
      end
      draw = (model_text < cfg_window) ? model_text : cfg_window;
      span = model_text - draw;
      if (32'(model_frame) < 32'(cfg_hold))
         pix = '0;
      else
         pix = ((64'(model_frame) - 64'(cfg_hold)) * 64'(spd)) / 64'(SPEED_DIV);
      cur  = (pix > 64'(span)) ? span : pix[PIX_W-1:0];
      rest = span - cur;
      res.draw   = draw;
      res.offset = cur;
      res.fade_l = (cur < cfg_fade) ? cur : cfg_fade;
      res.fade_r = (rest < cfg_fade) ? rest : cfg_fade;
      res.frame  = model_frame;
      return res;
   endfunction

   function automatic stim_row_type req_row(input req_kind_type kind,
                                            input logic [PIX_W-1:0] width);
      stim_row_type r;
      r.row       = ROW_REQ;
      r.kind      = kind;
      r.width     = width;
      r.csr_index = REG_WINDOW_WIDTH;
      r.value     = '0;
      r.typed     = 1'b0;
      r.want      = '0;
      return r;
   endfunction

   function automatic stim_row_type typed_row(input req_kind_type kind,
                                              input logic [PIX_W-1:0] width,
                                              input crop_type want);
      stim_row_type r;
      r       = req_row(kind, width);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input reg_index_type idx,
                                            input logic [31:0] value);
      stim_row_type r;
      r           = req_row(REQ_TICK, '0);
      r.row       = ROW_CSR;
      r.csr_index = idx;
      r.value     = value;
      return r;
   endfunction

   function automatic void note_error(input string what, input crop_type want,
                                      input crop_type got);
      error_count++;
      if (error_count <= 10)
         $display("%s: exp draw=%0d ofs=%0d fl=%0d fr=%0d frame=%0d, got draw=%0d ofs=%0d fl=%0d fr=%0d frame=%0d",
                  what, want.draw, want.offset, want.fade_l, want.fade_r, want.frame,
                  got.draw, got.offset, got.fade_l, got.fade_r, got.frame);
   endfunction

   // Offer one request transaction; return at the edge that accepts it.
   task automatic offer(input req_kind_type kind, input logic [PIX_W-1:0] width,
                        input bit typed, input crop_type want);
      int       gap;
      crop_type predicted;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_new_text_width <= width;
      do @(posedge clock); while (req_stall);
      predicted = advance_marquee(kind, width);
      pending_crops.push_back(typed ? want : predicted);
   endtask

   // Drop valid and hold until every outstanding crop has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_crops.size() != 0) @(posedge clock);
   endtask

   // Setup and access cycle; upper pwdata bits carry junk the block must mask.
   task automatic write_csr(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] noise;
      mask  = (idx == REG_HOLD_LENGTH) ? 32'h0000_7FFF : 32'h0000_FFFF;
      noise = $urandom();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= (value & mask) | (noise & ~mask);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_WINDOW_WIDTH: cfg_window = value[PIX_W-1:0];
         REG_SCROLL_SPEED: cfg_speed  = value[PIX_W-1:0];
         REG_HOLD_LENGTH:  cfg_hold   = value[HOLD_W-1:0];
         REG_FADE_LIMIT:   cfg_fade   = value[PIX_W-1:0];
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Response side: random stall before each transaction, plus the odd long hold-off.
   initial begin
      int n;
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_offs_pending > 0) begin
            hold_offs_pending--;
            n = HOLD_OFF_LEN;
         end else begin
            n = idle_on ? $urandom_range(0, 4) : 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare each accepted response against the oldest pending crop.
   always @(posedge clock) begin : check_crop
      crop_type got;
      crop_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_draw_width, rsp_pixel_offset, rsp_fade_left, rsp_fade_right,
                rsp_frame_index};
         if (pending_crops.size() == 0) begin
            note_error("unexpected crop", got, got);
         end else begin
            want = pending_crops.pop_front();
            if (got !== want)
               note_error("crop mismatch", want, got);
         end
      end
   end

   initial begin
      int               random_sent;
      int               phase;
      int               phase_len;
      int               r;
      int               wide;
      logic [PIX_W-1:0] width;
      logic [PIX_W-1:0] win;
      logic [PIX_W-1:0] spd;
      logic [HOLD_W-1:0] hold;
      logic [PIX_W-1:0] fade;
      stim_row_type     row;

      // Drive every input to a known value before the first edge.
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_valid          = 1'b0;
      req_type           = REQ_SET_WIDTH;
      req_new_text_width = '0;
      cfg_window         = '0;
      cfg_speed          = 16'd10;
      cfg_hold           = '0;
      cfg_fade           = '0;
      model_text         = '0;
      model_frame        = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Typed rows are read straight off the spec; the rest use
      // the shadow model. Opening rows run on reset register values.
      dir_rows.push_back(typed_row(REQ_SET_WIDTH, 16'd0, '0));
      // zero-length cycle: the tick falls straight back to frame 0
      dir_rows.push_back(typed_row(REQ_TICK, 16'd0, '0));
      dir_rows.push_back(typed_row(REQ_SET_WIDTH, 16'hFFFF, '0));
      dir_rows.push_back(typed_row(REQ_TICK, 16'd0, {16'd0, 16'd1, 16'd0, 16'd0, 16'd1}));
      // same width again: frame must not clear
      dir_rows.push_back(typed_row(REQ_SET_WIDTH, 16'hFFFF,
                                   {16'd0, 16'd1, 16'd0, 16'd0, 16'd1}));
      dir_rows.push_back(csr_row(REG_FADE_LIMIT, 32'hFFFF));
      dir_rows.push_back(typed_row(REQ_TICK, 16'hFFFF,
                                   {16'd0, 16'd2, 16'd2, 16'd65533, 16'd2}));
      // text exactly as wide as the window with no hold: empty cycle
      dir_rows.push_back(csr_row(REG_WINDOW_WIDTH, 32'hFFFF));
      dir_rows.push_back(typed_row(REQ_TICK, 16'h1234, {16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0}));
      dir_rows.push_back(csr_row(REG_SCROLL_SPEED, 32'h0));
      dir_rows.push_back(csr_row(REG_HOLD_LENGTH, 32'h7FFF));
      // text narrower than the window: frame pinned at zero
      dir_rows.push_back(typed_row(REQ_SET_WIDTH, 16'd100, {16'd100, 16'd0, 16'd0, 16'd0, 16'd0}));
      dir_rows.push_back(typed_row(REQ_TICK, 16'd0, {16'd100, 16'd0, 16'd0, 16'd0, 16'd0}));
      dir_rows.push_back(csr_row(REG_WINDOW_WIDTH, 32'd40));
      dir_rows.push_back(req_row(REQ_TICK, 16'd0));
      dir_rows.push_back(req_row(REQ_TICK, 16'hFFFF));
      dir_rows.push_back(csr_row(REG_HOLD_LENGTH, 32'h0));
      dir_rows.push_back(csr_row(REG_SCROLL_SPEED, 32'hFFFF));
      dir_rows.push_back(req_row(REQ_TICK, 16'd0));
      dir_rows.push_back(csr_row(REG_SCROLL_SPEED, 32'd7));
      dir_rows.push_back(csr_row(REG_FADE_LIMIT, 32'd5));
      dir_rows.push_back(req_row(REQ_TICK, 16'd0));
      dir_rows.push_back(req_row(REQ_TICK, 16'd0));
      dir_rows.push_back(req_row(REQ_SET_WIDTH, 16'd39));
      dir_rows.push_back(req_row(REQ_TICK, 16'd0));

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.row == ROW_CSR) begin
            drain_results();
            write_csr(row.csr_index, row.value);
         end else begin
            offer(row.kind, row.width, row.typed, row.want);
         end
      end

      // Random phases: new registers each phase, then mostly ticks on text a
      // little wider than the window so the frame can wrap within the phase.
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         drain_results();
         case (phase)
            0: begin
               win = 16'hFFFF; spd = 16'hFFFF; hold = 15'h7FFF; fade = 16'hFFFF;
            end
            1: begin
               win = '0; spd = '0; hold = '0; fade = '0;
            end
            default: begin
               r = $urandom_range(0, 3);
               case (r)
                  0: win = 16'($urandom_range(0, 65535));
                  1: win = 16'($urandom_range(0, 200));
                  2: win = 16'hFFFF - 16'($urandom_range(0, 50));
                  default: win = '0;
               endcase
               r = $urandom_range(0, 5);
               case (r)
                  0: spd = '0;
                  1: spd = 16'($urandom_range(0, 65535));
                  default: spd = 16'($urandom_range(1, 40));
               endcase
               hold = ($urandom_range(0, 7) == 0) ? 15'($urandom_range(0, 32767))
                                                  : 15'($urandom_range(0, 6));
               r = $urandom_range(0, 3);
               case (r)
                  0: fade = 16'hFFFF;
                  1: fade = 16'($urandom_range(0, 65535));
                  default: fade = 16'($urandom_range(0, 8));
               endcase
            end
         endcase
         write_csr(REG_WINDOW_WIDTH, 32'(win));
         write_csr(REG_SCROLL_SPEED, 32'(spd));
         write_csr(REG_HOLD_LENGTH, 32'(hold));
         write_csr(REG_FADE_LIMIT, 32'(fade));

         idle_on = ($urandom_range(0, 3) != 0);
         // back up the block: the response side holds off while requests keep coming
         if (phase == 2 || $urandom_range(0, 3) == 0)
            hold_offs_pending = 1;

         phase_len = $urandom_range(40, 70);
         for (int k = 0; k < phase_len; k++) begin
            r = $urandom_range(0, 99);
            wide = int'(cfg_window) + $urandom_range(0, 30);
            if (wide > 65535)
               wide = 65535;
            if (k == 0 || (r >= 82 && r < 92)) begin
               offer(REQ_SET_WIDTH, 16'(wide), 1'b0, '0);
            end else if (r < 72) begin
               // width bits on a tick are don't-care; keep them noisy
               width = 16'($urandom_range(0, 65535));
               offer(REQ_TICK, width, 1'b0, '0);
            end else if (r < 82) begin
               offer(REQ_SET_WIDTH, model_text, 1'b0, '0);
            end else if (r < 96) begin
               width = 16'($urandom_range(0, 65535));
               offer(REQ_SET_WIDTH, width, 1'b0, '0);
            end else begin
               width = (cfg_window == '0) ? '0 : 16'($urandom_range(0, int'(cfg_window) - 1));
               offer(REQ_SET_WIDTH, width, 1'b0, '0);
            end
            random_sent++;
         end
         phase++;
      end

      // Flush, then watch a little longer for stray responses.
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_crops.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
